// ----- hdl/mma_pkg.sv -----
// Shared constants, codes and types of the matrix multiply engine.
package mma_pkg;

    localparam int MAX_DIM     = 128;
    localparam int STORE_DEPTH = 16384;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SQ_W        = ADDR_W + 1;
    localparam int DIM_W       = 8;
    localparam int LAT_W       = 32;
    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 32;

    localparam logic [CMD_W-1:0] CMD_WRITE_A = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LATENCY   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_UNLOAD
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  tag;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
    } operand_t;

    typedef struct packed {
        logic clr;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_value;
        logic              busy_res;
        logic              done_res;
    } result_t;

endpackage

// ----- hdl/mma_if.sv -----
// Command and result channel interfaces of the matrix multiply engine.
interface mma_cmd_if import mma_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] element_index;
    logic [BYTE_W-1:0] element_value;

    modport source (output valid, output command, output element_index,
                    output element_value, input ready);
    modport sink   (input valid, input command, input element_index,
                    input element_value, output ready);
endinterface

interface mma_res_if import mma_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_value;
    logic              busy_res;
    logic              done_res;

    modport source (output valid, output read_value, output busy_res,
                    output done_res, input ready);
    modport sink   (input valid, input read_value, input busy_res,
                    input done_res, output ready);
endinterface

// ----- hdl/mma_cell.sv -----
// One multiply-accumulate cell: owns one product column of the current row.
module mma_cell import mma_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  operand_t          op_in,
    output operand_t          op_out,
    input  logic [BYTE_W-1:0] acc_in,
    output logic [BYTE_W-1:0] acc_out
);

    logic                hit;
    logic [2*BYTE_W-1:0] prod;
    logic                valid_next;
    logic [BYTE_W-1:0]   acc_next;

    logic                valid_reg;
    logic [IDX_W-1:0]    tag_reg;
    logic [BYTE_W-1:0]   a_reg;
    logic [BYTE_W-1:0]   b_reg;
    logic [BYTE_W-1:0]   acc_reg;

    always_comb
    begin
        hit        = op_in.valid && (op_in.tag == '0);
        prod       = op_in.a * op_in.b;
        valid_next = op_in.valid && !hit;
        priority if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (ctl.shift)
        begin
            acc_next = acc_in;
        end
        else if (hit)
        begin
            acc_next = acc_reg + prod[BYTE_W-1:0];
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // tag counts down cell by cell; zero marks the owning column
    always_ff @(posedge clk)
    begin
        tag_reg <= op_in.tag - 1'b1;
        a_reg   <= op_in.a;
        b_reg   <= op_in.b;
        acc_reg <= acc_next;
    end

    assign op_out.valid = valid_reg;
    assign op_out.tag   = tag_reg;
    assign op_out.a     = a_reg;
    assign op_out.b     = b_reg;
    assign acc_out      = acc_reg;

endmodule

// ----- hdl/mma_chain.sv -----
// Row of MAX_DIM cells: operands flow towards the tail, sums unload towards the head.
module mma_chain import mma_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  operand_t          op_in,
    output logic [BYTE_W-1:0] head_acc,
    output logic              tail_valid
);

    operand_t          ops  [MAX_DIM+1];
    logic [BYTE_W-1:0] accs [MAX_DIM+1];

    assign ops[0]        = op_in;
    assign accs[MAX_DIM] = '0;

    for (genvar i = 0; i < MAX_DIM; i++)
    begin : g_cell
        mma_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .op_in   (ops[i]),
            .op_out  (ops[i+1]),
            .acc_in  (accs[i+1]),
            .acc_out (accs[i])
        );
    end

    assign head_acc   = accs[0];
    assign tail_valid = ops[MAX_DIM].valid;

endmodule

// ----- hdl/matrix_multiply_accelerator.sv -----
// Top level of the matrix multiply engine: stores, sequencer, cell chain and result queue.
//
//   port    | role             | transaction / write
//   --------+------------------+-------------------------------------------------
//   cmd     | command in       | command, element_index, element_value
//   res     | result out       | read_value, busy_res, done_res (one per command)
//   cfg_*   | register write   | cfg_index 0 dimension, 1 compute_latency
//
// Loads, reads, starts and non-completing ticks: one per cycle when idle, queue not full;
// each result is registered in the s1 stage, then in the result queue. A completing tick
// holds cmd.ready low while each row (d the dimension) streams d*d operand pairs through
// the single B read port, then drains and unloads d sums on the single product write port.
// After reset a clearing pass over 16384 addresses zeroes all three stores; no command
// is taken meanwhile. A stalled res side backs up a two-entry queue, then cmd.ready.
module matrix_multiply_accelerator import mma_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mma_cmd_if.sink              cmd,
    mma_res_if.source            res
);

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [DIM_W-1:0]  DIM_MAX   = DIM_W'(MAX_DIM);

    state_t              state_reg, state_next;

    logic [DIM_W-1:0]    cfg_dim;
    logic [DIM_W-1:0]    cfg_eff;
    logic [2*DIM_W-1:0]  cfg_sq;
    logic [DIM_W-1:0]    dim_reg;
    logic [SQ_W-1:0]     dim_sq_reg;
    logic [LAT_W-1:0]    lat_reg;

    logic                busy_reg, busy_next;
    logic [LAT_W-1:0]    ticks_reg, ticks_next;
    logic [LAT_W-1:0]    ticks_dec;

    logic                cmd_fire;
    logic                cmd_ready;
    logic                tick_done;
    logic                a_host_we, b_host_we;
    logic                rd_ok;

    logic [IDX_W-1:0]    dm1_reg, col_reg, k_reg, row_reg;
    logic                col_last, k_last, row_last;
    logic [ADDR_W-1:0]   clr_addr_reg, a_addr_reg, b_addr_reg, p_addr_reg;

    logic                clearing, unload;
    cell_ctl_t           ctl;
    operand_t            feed;
    logic                fv_reg;
    logic [IDX_W-1:0]    ftag_reg;
    logic [BYTE_W-1:0]   head_acc;
    logic                tail_valid;

    logic [BYTE_W-1:0]   a_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]   b_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]   p_mem [STORE_DEPTH];
    logic                a_we, b_we, p_we;
    logic [ADDR_W-1:0]   a_waddr, b_waddr, p_waddr;
    logic [BYTE_W-1:0]   a_wdata, b_wdata, p_wdata;
    logic [BYTE_W-1:0]   a_rdata, b_rdata, p_rdata;

    logic                s1_valid_reg, s1_rd_ok_reg, s1_busy_reg, s1_done_reg;

    result_t             fifo_reg [2];
    result_t             push_res;
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic [1:0]          occ;
    logic                push, pop;

    // ---------------- configuration ----------------
    always_comb
    begin
        cfg_dim = cfg_data[DIM_W-1:0];
        cfg_eff = (cfg_dim > DIM_MAX) ? DIM_MAX : cfg_dim;
        cfg_sq  = cfg_eff * cfg_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg    <= '0;
            dim_sq_reg <= '0;
            lat_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIMENSION:
                begin
                    dim_reg    <= cfg_eff;
                    dim_sq_reg <= SQ_W'(cfg_sq);
                end
                REG_LATENCY:
                begin
                    lat_reg <= cfg_data[LAT_W-1:0];
                end
            endcase
        end
    end

    // ---------------- command decode ----------------
    assign pop      = res.valid && res.ready;
    assign occ      = cnt_reg + {1'b0, s1_valid_reg};
    assign cmd_fire = cmd.valid && cmd_ready;

    always_comb
    begin
        ticks_dec  = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;
        busy_next  = busy_reg;
        ticks_next = ticks_reg;
        tick_done  = 1'b0;
        a_host_we  = 1'b0;
        b_host_we  = 1'b0;
        rd_ok      = 1'b0;
        if (cmd_fire)
        begin
            unique case (cmd.command)
                CMD_WRITE_A: a_host_we = 1'b1;
                CMD_WRITE_B: b_host_we = 1'b1;
                CMD_START:
                begin
                    if (!busy_reg)
                    begin
                        busy_next  = 1'b1;
                        ticks_next = lat_reg;
                    end
                end
                CMD_TICK:
                begin
                    if (busy_reg)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == '0)
                        begin
                            busy_next = 1'b0;
                            tick_done = 1'b1;
                        end
                    end
                end
                CMD_READ: rd_ok = {1'b0, cmd.element_index} < dim_sq_reg;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign col_last = (col_reg == dm1_reg);
    assign k_last   = (k_reg == dm1_reg);
    assign row_last = (row_reg == dm1_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (tick_done && (dim_reg != '0))
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (col_last && k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (col_last)
                begin
                    state_next = ST_UNLOAD;
                end
            end
            ST_UNLOAD:
            begin
                if (col_last)
                begin
                    state_next = row_last ? ST_IDLE : ST_FEED;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        clearing  = 1'b0;
        unload    = 1'b0;
        ctl       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                ctl.clr  = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_ready = (occ != 2'd2) || pop;
                ctl.clr   = 1'b1;
            end
            ST_FEED, ST_DRAIN: ;
            ST_UNLOAD:
            begin
                unload    = 1'b1;
                ctl.shift = 1'b1;
            end
        endcase
    end

    assign cmd.ready = cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            busy_reg     <= 1'b0;
            ticks_reg    <= '0;
            clr_addr_reg <= '0;
            dm1_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
            row_reg      <= '0;
            a_addr_reg   <= '0;
            b_addr_reg   <= '0;
            p_addr_reg   <= '0;
            fv_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            ticks_reg <= ticks_next;
            fv_reg    <= (state_reg == ST_FEED);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (tick_done)
                    begin
                        dm1_reg    <= IDX_W'(dim_reg - 1'b1);
                        col_reg    <= '0;
                        k_reg      <= '0;
                        row_reg    <= '0;
                        a_addr_reg <= '0;
                        b_addr_reg <= '0;
                        p_addr_reg <= '0;
                    end
                end
                ST_FEED:
                begin
                    // B walks row-major, A steps once per B row
                    if (col_last)
                    begin
                        col_reg    <= '0;
                        a_addr_reg <= a_addr_reg + 1'b1;
                        if (k_last)
                        begin
                            k_reg      <= '0;
                            b_addr_reg <= '0;
                        end
                        else
                        begin
                            k_reg      <= k_reg + 1'b1;
                            b_addr_reg <= b_addr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg    <= col_reg + 1'b1;
                        b_addr_reg <= b_addr_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    col_reg <= col_last ? '0 : col_reg + 1'b1;
                end
                ST_UNLOAD:
                begin
                    p_addr_reg <= p_addr_reg + 1'b1;
                    col_reg    <= col_last ? '0 : col_reg + 1'b1;
                    if (col_last && !row_last)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ftag_reg <= col_reg;
    end

    // ---------------- stores ----------------
    always_comb
    begin
        a_we    = clearing || a_host_we;
        a_waddr = clearing ? clr_addr_reg : cmd.element_index;
        a_wdata = clearing ? '0 : cmd.element_value;
        b_we    = clearing || b_host_we;
        b_waddr = clearing ? clr_addr_reg : cmd.element_index;
        b_wdata = clearing ? '0 : cmd.element_value;
        p_we    = clearing || unload;
        p_waddr = clearing ? clr_addr_reg : p_addr_reg;
        p_wdata = clearing ? '0 : head_acc;
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= a_wdata;
        end
        a_rdata <= a_mem[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        b_rdata <= b_mem[b_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= p_mem[cmd.element_index];
    end

    // ---------------- cell chain ----------------
    assign feed.valid = fv_reg;
    assign feed.tag   = ftag_reg;
    assign feed.a     = a_rdata;
    assign feed.b     = b_rdata;

    mma_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .op_in      (feed),
        .head_acc   (head_acc),
        .tail_valid (tail_valid)
    );

    // ---------------- result path ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rd_ok_reg <= rd_ok;
        s1_busy_reg  <= busy_next;
        s1_done_reg  <= tick_done;
    end

    assign push                = s1_valid_reg;
    assign push_res.read_value = s1_rd_ok_reg ? p_rdata : '0;
    assign push_res.busy_res   = s1_busy_reg;
    assign push_res.done_res   = s1_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_res;
        end
    end

    assign res.valid      = (cnt_reg != '0);
    assign res.read_value = fifo_reg[rd_ptr_reg].read_value;
    assign res.busy_res   = fifo_reg[rd_ptr_reg].busy_res;
    assign res.done_res   = fifo_reg[rd_ptr_reg].done_res;

    // ---------------- assertions ----------------
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg + {1'b0, s1_valid_reg}) <= 2'd2)
        else $error("result queue plus pending transaction exceeds two");

    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !tail_valid)
        else $error("operand left the end of the cell chain unconsumed");

    a_done_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_FEED)
        |=> (s1_valid_reg && s1_done_reg && !s1_busy_reg))
        else $error("product computation began without a completing tick");

endmodule

// ----- verif/matrix_multiply_accelerator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the matrix multiply engine: directed table, then random phases.
module matrix_multiply_accelerator_tb;
    import mma_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_SPARE_5  = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_SPARE_7  = 3'd7;
    localparam logic [ADDR_W-1:0] TOP_INDEX    = ADDR_W'(STORE_DEPTH - 1);
    localparam int                CYCLE_LIMIT  = 1_000_000;
    localparam int                RANDOM_ITEMS = 1150;
    localparam int                DRAIN_CYCLES = 20;

    localparam result_t QUIET_RES = '{8'h00, 1'b0, 1'b0};
    localparam result_t BUSY_RES  = '{8'h00, 1'b1, 1'b0};
    localparam result_t DONE_RES  = '{8'h00, 1'b0, 1'b1};

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]     reg_val;
        logic [CMD_W-1:0]     op;
        logic [ADDR_W-1:0]    idx;
        logic [BYTE_W-1:0]    val;
        logic                 typed;
        result_t              want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [28] = '{
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    14'd0,     8'h00, 1'b1, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    TOP_INDEX, 8'h00, 1'b1, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_SPARE_5, TOP_INDEX, 8'hFF, 1'b1, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_SPARE_7, 14'd0,     8'h00, 1'b1, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_TICK,    14'd0,     8'h00, 1'b1, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_START,   14'd0,     8'h00, 1'b1, BUSY_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_START,   TOP_INDEX, 8'hFF, 1'b1, BUSY_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_TICK,    14'd0,     8'h00, 1'b1, DONE_RES},
        '{1'b1, REG_DIMENSION, 32'hA5A5_A502, CMD_READ, 14'd0, 8'h00, 1'b0, QUIET_RES},
        '{1'b1, REG_LATENCY,   32'd2, CMD_READ,    14'd0,     8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_A, 14'd0,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_A, 14'd1,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_A, 14'd2,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_A, 14'd3,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_B, 14'd0,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_B, 14'd1,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_B, 14'd2,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_B, 14'd3,     8'hFF, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_WRITE_A, TOP_INDEX, 8'h5A, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_START,   14'd0,     8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_TICK,    14'd0,     8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_TICK,    14'd0,     8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    14'd0,     8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    14'd3,     8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    14'd4,     8'h00, 1'b0, QUIET_RES},
        '{1'b1, REG_DIMENSION, 32'h0000_00FF, CMD_READ, 14'd0, 8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    TOP_INDEX, 8'h00, 1'b0, QUIET_RES},
        '{1'b0, REG_DIMENSION, 32'd0, CMD_READ,    14'd3,     8'h00, 1'b0, QUIET_RES}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mma_cmd_if cmd_if ();
    mma_res_if res_if ();

    matrix_multiply_accelerator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // engine shadow
    logic [BYTE_W-1:0] mat_a [STORE_DEPTH];
    logic [BYTE_W-1:0] mat_b [STORE_DEPTH];
    logic [BYTE_W-1:0] mat_p [STORE_DEPTH];
    logic              eng_busy;
    logic [LAT_W-1:0]  ticks_to_go;
    logic [DIM_W-1:0]  dim_reg;
    logic [LAT_W-1:0]  latency_reg;

    result_t pending_results [$];

    int errors        = 0;
    int useful_items  = 0;
    int products_done = 0;
    int config_writes = 0;
    int cycles        = 0;
    int burst_left    = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    int stall_left    = 0;
    int stall_phase   = 0;

    always #1 clk = ~clk;

    function automatic int active_dim();
        return (int'(dim_reg) > MAX_DIM) ? MAX_DIM : int'(dim_reg);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return BYTE_W'($urandom());
        endcase
    endfunction

    task automatic multiply_stores();
        int d;
        int acc;
        d = active_dim();
        for (int r = 0; r < d; r++)
        begin
            for (int c = 0; c < d; c++)
            begin
                acc = 0;
                for (int k = 0; k < d; k++)
                    acc += int'(mat_a[r*d + k]) * int'(mat_b[k*d + c]);
                mat_p[r*d + c] = acc[BYTE_W-1:0];
            end
        end
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] idx,
                                 input logic [BYTE_W-1:0] val, output result_t r);
        int d;
        r = QUIET_RES;
        d = active_dim();
        case (op)
            CMD_WRITE_A: mat_a[idx] = val;
            CMD_WRITE_B: mat_b[idx] = val;
            CMD_START:
            begin
                if (!eng_busy)
                begin
                    eng_busy    = 1'b1;
                    ticks_to_go = latency_reg;
                end
            end
            CMD_TICK:
            begin
                if (eng_busy)
                begin
                    if (ticks_to_go != 0)
                        ticks_to_go--;
                    if (ticks_to_go == 0)
                    begin
                        multiply_stores();
                        eng_busy = 1'b0;
                        r.done_res = 1'b1;
                        products_done++;
                    end
                end
            end
            CMD_READ:
            begin
                if (int'(idx) < d*d)
                    r.read_value = mat_p[idx];
            end
            default: ;
        endcase
        r.busy_res = eng_busy;
    endtask

    task automatic report(input string what, input result_t got, input result_t want);
        $display("%0t ERROR %s: got value %02h busy %b done %b, expected value %02h busy %b done %b",
                 $time, what, got.read_value, got.busy_res, got.done_res,
                 want.read_value, want.busy_res, want.done_res);
        errors++;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic typed = 1'b0,
                             input result_t want = QUIET_RES);
        result_t predicted;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                7:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= op;
        cmd_if.element_index <= idx;
        cmd_if.element_value <= val;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        apply_command(op, idx, val, predicted);
        pending_results.push_back(typed ? want : predicted);
        if (op <= CMD_READ)
            useful_items++;
    endtask

    task automatic send_noise();
        send_item(CMD_W'($urandom_range(0, 7)), ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                  pick_byte());
    endtask

    // hold off the sender until every outstanding transaction has come back
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (sel == REG_DIMENSION)
            dim_reg = data[DIM_W-1:0];
        else
            latency_reg = data;
        config_writes++;
    endtask

    task automatic set_config(input int d, input logic [LAT_W-1:0] lat);
        logic [CFG_W-1:0] dim_word;
        dim_word = $urandom_range(0, 1) ? CFG_W'($urandom()) : '0;
        dim_word[DIM_W-1:0] = DIM_W'(d);
        wait_idle();
        write_register(REG_DIMENSION, dim_word);
        write_register(REG_LATENCY, lat);
    endtask

    task automatic multiply_phase(input int d);
        logic [LAT_W-1:0]  lat;
        logic [ADDR_W-1:0] idx;
        int                cells;
        int                n_loads;
        case ($urandom_range(0, 9))
            0, 1, 2: lat = '0;
            8:       lat = LAT_W'($urandom_range(7, 20));
            9:       lat = LAT_W'($urandom_range(40, 60));
            default: lat = LAT_W'($urandom_range(1, 6));
        endcase
        set_config(d, lat);
        cells   = d*d;
        n_loads = (cells <= 36) ? cells : 30;
        for (int e = 0; e < n_loads; e++)
        begin
            idx = (cells <= 36) ? ADDR_W'(e) : ADDR_W'($urandom_range(0, cells - 1));
            send_item(CMD_WRITE_A, idx, pick_byte());
            if ($urandom_range(0, 9) == 0)
                send_noise();
            idx = (cells <= 36) ? ADDR_W'(e) : ADDR_W'($urandom_range(0, cells - 1));
            send_item(CMD_WRITE_B, idx, pick_byte());
        end
        if ($urandom_range(0, 5) == 0)
            wait_idle();
        send_item(CMD_START, ADDR_W'($urandom()), pick_byte());
        while (eng_busy)
        begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_READ, (cells > 0) ? ADDR_W'($urandom_range(0, cells - 1)) : '0,
                          pick_byte());
            send_item(CMD_TICK, ADDR_W'($urandom()), pick_byte());
        end
        for (int e = 0; e < n_loads; e++)
            send_item(CMD_READ, (cells <= 36) ? ADDR_W'(e)
                                              : ADDR_W'($urandom_range(0, cells - 1)), 8'h00);
        send_item(CMD_READ, ADDR_W'(cells), pick_byte());
        send_item(CMD_READ, TOP_INDEX, pick_byte());
        send_item(CMD_READ, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), pick_byte());
    endtask

    // full-size addressing without a product: engine stays idle throughout
    task automatic wide_phase();
        logic [CMD_W-1:0]  op;
        logic [ADDR_W-1:0] idx;
        set_config($urandom_range(MAX_DIM, 255), LAT_W'($urandom()));
        for (int n = 0; n < 40; n++)
        begin
            case ($urandom_range(0, 5))
                0:       op = CMD_WRITE_A;
                1:       op = CMD_WRITE_B;
                2, 3:    op = CMD_READ;
                4:       op = CMD_TICK;
                default: op = CMD_W'($urandom_range(5, 7));
            endcase
            idx = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(STORE_DEPTH - 384,
                                                                       STORE_DEPTH - 1))
                                              : ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
            send_item(op, idx, pick_byte());
        end
    endtask

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 5;
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            2: res_if.ready <= (stall_phase != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    res_if.ready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 31) == 0)
                        stall_left = $urandom_range(5, 30);
                    res_if.ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{res_if.read_value, res_if.busy_res, res_if.done_res};
            if (pending_results.size() == 0)
                report("transaction with nothing expected", got, QUIET_RES);
            else
            begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res)
                    report("result mismatch", got, want);
            end
        end
    end

    initial
    begin
        int d;
        int phase;
        int random_start;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = '0;
        cmd_if.element_index = '0;
        cmd_if.element_value = '0;
        res_if.ready         = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            mat_a[i] = '0;
            mat_b[i] = '0;
            mat_p[i] = '0;
        end
        eng_busy    = 1'b0;
        ticks_to_go = '0;
        dim_reg     = '0;
        latency_reg = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].is_cfg)
            begin
                wait_idle();
                write_register(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
            end
            else
                send_item(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].val,
                          DIRECTED[i].typed, DIRECTED[i].want);
        end

        random_start = useful_items;
        phase = 0;
        while (useful_items - random_start < RANDOM_ITEMS)
        begin
            if (phase % 9 == 4)
                wide_phase();
            else if (phase == 7)
                multiply_phase(16);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       d = 0;
                    9:       d = $urandom_range(7, 8);
                    default: d = $urandom_range(1, 5);
                endcase
                multiply_phase(d);
            end
            phase++;
        end

        // longest latency: the engine stays busy for the rest of the run
        set_config(3, '1);
        send_item(CMD_START, '0, 8'h00);
        repeat (6) send_item(CMD_TICK, ADDR_W'($urandom()), pick_byte());
        send_item(CMD_READ, '0, 8'h00);
        send_item(CMD_START, TOP_INDEX, 8'hFF);

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d load/start/tick/read transactions over %0d phases, %0d products",
                 useful_items, phase + 2, products_done);
        $display("%0d register writes, dimensions 0 to 255, latency 0 to all ones", config_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- matrix_multiply_accelerator.f -----
hdl/mma_pkg.sv
hdl/mma_if.sv
hdl/mma_cell.sv
hdl/mma_chain.sv
hdl/matrix_multiply_accelerator.sv
verif/matrix_multiply_accelerator_tb.sv
